[rtl/pae_pkg.sv]
// Package for the polygon angular extent block.
// Holds widths, the CORDIC arctangent table, sequencer and tracker types.
// No dependencies; every other rtl file imports it.
package pae_pkg;

	localparam int COORD_BITS   = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int ACC_BITS     = 24;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int CW_BITS      = DIFF_BITS + 19;
	localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
	localparam int VERT_BITS    = 2 * COORD_BITS;
	localparam int WRAP_BITS    = ANGLE_BITS + 1;
	localparam int EDGE_BITS    = VERT_BITS + WRAP_BITS;
	localparam int OUT_BITS     = ((EDGE_BITS + 7) / 8) * 8;
	localparam int REG_IDX_BITS = 1;

	localparam logic [31:0] Z_QUARTER = 32'h4000_0000;
	localparam logic [31:0] Z_THREE_Q = 32'hC000_0000;
	localparam logic [31:0] Z_ROUND   = 32'h1 << (31 - ANGLE_BITS);
	localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

	localparam logic [REG_IDX_BITS-1:0] REG_VIEWPOINT_X = 1'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_VIEWPOINT_Y = 1'd1;

	localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_CLOSE,
		ST_EMIT
	} pae_state_t;

	typedef enum logic [1:0] {
		TRK_NONE,
		TRK_STEP,
		TRK_CLOSE
	} trk_op_t;

	typedef struct packed {
		trk_op_t                op;
		logic [ANGLE_BITS-1:0]  bearing;
		logic [VERT_BITS-1:0]   vertex;
	} trk_req_t;

	typedef struct packed {
		logic [VERT_BITS-1:0]  min_vertex;
		logic [VERT_BITS-1:0]  max_vertex;
		logic [ACC_BITS-1:0]   min_angle;
		logic [ACC_BITS-1:0]   max_angle;
	} trk_ext_t;

	// reduce one turn residue into ]-half,half]
	function automatic logic [WRAP_BITS-1:0] wrap_turn(input logic [ANGLE_BITS-1:0] w);
		wrap_turn = (w > HALF_TURN) ? {1'b1, w} : {1'b0, w};
	endfunction

endpackage

[rtl/polygon_angular_extent_top.sv]
// Each accepted vertex item is loaded, runs 16 iterations of the shared CORDIC
// add/shift unit (one per cycle) and is then accumulated and compared before
// the block is ready again. A final vertex then closes the polygon and loads
// the edge items (minimum edge first, tuser and tlast high on the maximum
// edge); that load waits until any earlier edge pair has been taken. Viewpoint
// writes apply to later items.
// Top level: sequencer, viewpoint registers and edge output; uses pae_pkg,
// pae_cordic and pae_track.
module polygon_angular_extent_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pae_pkg::REG_IDX_BITS-1:0]     cfg_index,
	input  logic [pae_pkg::COORD_BITS-1:0]       cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [pae_pkg::VERT_BITS-1:0]        s_tdata,   // vertex_x, vertex_y
	input  logic                                 s_tlast,   // final_vertex
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [pae_pkg::OUT_BITS-1:0]         m_tdata,   // edge_x, edge_y, edge_angle
	output logic                                 m_tuser,   // side
	output logic                                 m_tlast    // run_end
);
	import pae_pkg::*;

	pae_state_t state_q, state_d;
	logic [COORD_BITS-1:0] vp_x_q, vp_y_q;
	logic [VERT_BITS-1:0] vert_q;
	logic final_q;
	logic signed [DIFF_BITS-1:0] dx, dy;
	logic cordic_done;
	logic [ANGLE_BITS-1:0] bearing;
	trk_req_t req;
	trk_ext_t ext;
	logic [EDGE_BITS-1:0] hd_q, tl_q, min_edge, max_edge;
	logic hd_side_q;
	logic [1:0] cnt_q;
	logic accept, pop, load;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign pop       = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_x_q <= '0;
			vp_y_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VIEWPOINT_X: vp_x_q <= cfg_data;
				REG_VIEWPOINT_Y: vp_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dx = {s_tdata[COORD_BITS-1], s_tdata[COORD_BITS-1:0]}
		- {vp_x_q[COORD_BITS-1], vp_x_q};
	assign dy = {s_tdata[VERT_BITS-1], s_tdata[VERT_BITS-1:COORD_BITS]}
		- {vp_y_q[COORD_BITS-1], vp_y_q};

	pae_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.dx      (dx),
		.dy      (dy),
		.done    (cordic_done),
		.bearing (bearing)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			vert_q  <= s_tdata;
			final_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		load        = 1'b0;
		req.op      = TRK_NONE;
		req.bearing = bearing;
		req.vertex  = vert_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cordic_done) begin
					req.op  = TRK_STEP;
					state_d = final_q ? ST_CLOSE : ST_IDLE;
				end
			end
			ST_CLOSE: begin
				req.op  = TRK_CLOSE;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cnt_q == 2'd0) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	pae_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ext    (ext)
	);

	assign min_edge = {wrap_turn(ext.min_angle[ANGLE_BITS-1:0]), ext.min_vertex};
	assign max_edge = {wrap_turn(ext.max_angle[ANGLE_BITS-1:0]), ext.max_vertex};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= 2'd0;
			hd_side_q <= 1'b0;
		end else if (load) begin
			cnt_q     <= 2'd2;
			hd_side_q <= 1'b0;
		end else if (pop) begin
			cnt_q     <= cnt_q - 2'd1;
			hd_side_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hd_q <= min_edge;
			tl_q <= max_edge;
		end else if (pop) begin
			hd_q <= tl_q;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {{(OUT_BITS-EDGE_BITS){1'b0}}, hd_q};
	assign m_tuser  = hd_side_q;
	assign m_tlast  = hd_side_q;

endmodule

[rtl/pae_cordic.sv]
// Iterative vectoring CORDIC: one add/shift step per cycle on a shared unit.
// Gives the bearing of (dx, dy) as an ANGLE_BITS-bit fraction of a turn. Depends on pae_pkg.
module pae_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [pae_pkg::DIFF_BITS-1:0] dx,
	input  logic signed [pae_pkg::DIFF_BITS-1:0] dy,
	output logic                                done,
	output logic [pae_pkg::ANGLE_BITS-1:0]      bearing
);
	import pae_pkg::*;

	localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(CORDIC_STEPS - 1);

	logic signed [CW_BITS-1:0] x_q, y_q, xe, ye, x0, y0, xs, ys;
	logic [31:0] z_q, z0, zr;
	logic [STEP_BITS-1:0] cnt_q;
	logic busy_q, done_q, zero_q;

	always_comb begin
		xe = {{(CW_BITS-DIFF_BITS-16){dx[DIFF_BITS-1]}}, dx, 16'b0};
		ye = {{(CW_BITS-DIFF_BITS-16){dy[DIFF_BITS-1]}}, dy, 16'b0};
		x0 = xe;
		y0 = ye;
		z0 = '0;
		if (xe < 0) begin
			if (ye >= 0) begin
				x0 = ye;
				y0 = -xe;
				z0 = Z_QUARTER;
			end else begin
				x0 = -ye;
				y0 = xe;
				z0 = Z_THREE_Q;
			end
		end
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		zr = z_q + Z_ROUND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			zero_q <= (dx == '0) && (dy == '0);
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ATAN_TAB[cnt_q];
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ATAN_TAB[cnt_q];
			end
		end
	end

	assign done    = done_q;
	assign bearing = zero_q ? '0 : zr[31 -: ANGLE_BITS];

endmodule

[rtl/pae_track.sv]
// Unwrapped-angle accumulator with min/max tracking of the extreme vertices.
// One bearing step per request; close folds in the first vertex. Depends on pae_pkg.
module pae_track (
	input  logic              clk,
	input  logic              arst_n,
	input  pae_pkg::trk_req_t req,
	output pae_pkg::trk_ext_t ext
);
	import pae_pkg::*;

	logic first_pending_q;
	logic [VERT_BITS-1:0] first_vertex_q, min_vertex_q, max_vertex_q, vsel;
	logic [ANGLE_BITS-1:0] first_bearing_q, prev_bearing_q, bsel;
	logic signed [ACC_BITS-1:0] unwrapped_q, min_q, max_q, acc, init_acc;
	logic [WRAP_BITS-1:0] d;
	logic do_init, do_adv;

	always_comb begin
		bsel     = (req.op == TRK_CLOSE) ? first_bearing_q : req.bearing;
		vsel     = (req.op == TRK_CLOSE) ? first_vertex_q : req.vertex;
		d        = wrap_turn(bsel - prev_bearing_q);
		acc      = unwrapped_q + {{(ACC_BITS-WRAP_BITS){d[WRAP_BITS-1]}}, d};
		d        = wrap_turn(req.bearing);
		init_acc = {{(ACC_BITS-WRAP_BITS){d[WRAP_BITS-1]}}, d};
		d        = wrap_turn(bsel - prev_bearing_q);
		do_init  = (req.op == TRK_STEP) && first_pending_q;
		do_adv   = (req.op == TRK_CLOSE) || ((req.op == TRK_STEP) && !first_pending_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pending_q <= 1'b1;
			first_vertex_q  <= '0;
			first_bearing_q <= '0;
			prev_bearing_q  <= '0;
			unwrapped_q     <= '0;
			min_q           <= '0;
			max_q           <= '0;
			min_vertex_q    <= '0;
			max_vertex_q    <= '0;
		end else if (do_init) begin
			first_pending_q <= 1'b0;
			first_vertex_q  <= req.vertex;
			first_bearing_q <= req.bearing;
			prev_bearing_q  <= req.bearing;
			unwrapped_q     <= init_acc;
			min_q           <= init_acc;
			max_q           <= init_acc;
			min_vertex_q    <= req.vertex;
			max_vertex_q    <= req.vertex;
		end else if (do_adv) begin
			unwrapped_q    <= acc;
			prev_bearing_q <= bsel;
			if (min_q > acc) begin
				min_q        <= acc;
				min_vertex_q <= vsel;
			end
			if (max_q < acc) begin
				max_q        <= acc;
				max_vertex_q <= vsel;
			end
			if (req.op == TRK_CLOSE)
				first_pending_q <= 1'b1;
		end
	end

	assign ext.min_vertex = min_vertex_q;
	assign ext.max_vertex = max_vertex_q;
	assign ext.min_angle  = min_q;
	assign ext.max_angle  = max_q;

endmodule

[verif/tb_polygon_angular_extent_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for polygon_angular_extent_top: streams polygons, predicts the
// min/max bearing edges with a bit-exact CORDIC tracker, and checks every edge item.
// Depends on rtl/pae_pkg.sv and the block's RTL.
module tb_polygon_angular_extent_top;
	import pae_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int VERTEX_BUDGET = 1100;

	localparam logic [31:0] ARCTAN_STEP [0:15] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	typedef enum logic [1:0] {
		PL_VERTEX,
		PL_CFG,
		PL_DRAIN
	} plan_kind_t;

	typedef struct packed {
		plan_kind_t                kind;
		logic [REG_IDX_BITS-1:0]   idx;
		logic [COORD_BITS-1:0]     data;
		logic [COORD_BITS-1:0]     vx;
		logic [COORD_BITS-1:0]     vy;
		logic                      fin;
	} plan_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [16:0]           ang;
		logic                  side;
		logic                  run_end;
	} extreme_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [REG_IDX_BITS-1:0]   cfg_index = '0;
	logic [COORD_BITS-1:0]     cfg_data = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [VERT_BITS-1:0]      s_tdata = '0;
	logic                      s_tlast = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_BITS-1:0]       m_tdata;
	logic                      m_tuser;
	logic                      m_tlast;

	polygon_angular_extent_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	plan_t    plan_q[$];
	extreme_t pending_extremes[$];

	// tracker copy of the block state
	logic [COORD_BITS-1:0] vp_x = '0, vp_y = '0;
	logic                  first_pending = 1'b1;
	logic [COORD_BITS-1:0] first_x = '0, first_y = '0;
	logic [ANGLE_BITS-1:0] first_brg = '0, prev_brg = '0;
	logic signed [ACC_BITS-1:0] unwrapped = '0, min_ang = '0, max_ang = '0;
	logic [COORD_BITS-1:0] min_x = '0, min_y = '0, max_x = '0, max_y = '0;

	int err_count = 0;
	int n_vertices = 0, n_polygons = 0, n_extremes = 0, n_writes = 0;
	int planned_vertices = 0;
	bit quiet_s = 1'b0, quiet_m = 1'b0;

	task automatic enqueue_plan(input plan_t p);
		plan_q = {plan_q, p};
	endtask

	task automatic stash_extreme(input extreme_t e);
		pending_extremes = {pending_extremes, e};
	endtask

	function automatic int fold_turn(input logic [ANGLE_BITS-1:0] w);
		return (w > HALF_TURN) ? int'(w) - (1 << ANGLE_BITS) : int'(w);
	endfunction

	function automatic logic [ANGLE_BITS-1:0] cordic_bearing(input longint dx, input longint dy);
		longint x, y, t, nx, ny;
		logic [31:0] z;
		if (dx == 0 && dy == 0)
			return '0;
		x = dx * 65536;
		y = dy * 65536;
		z = '0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 32'h4000_0000;
			end else begin
				t = x; x = -y; y = t; z = 32'hC000_0000;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z = z + ARCTAN_STEP[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z = z - ARCTAN_STEP[i];
			end
			x = nx;
			y = ny;
		end
		z = z + (32'h1 << (31 - ANGLE_BITS));
		return z[31 -: ANGLE_BITS];
	endfunction

	task automatic accumulate(input logic [ANGLE_BITS-1:0] brg,
			input logic [COORD_BITS-1:0] vx, input logic [COORD_BITS-1:0] vy);
		logic [ANGLE_BITS-1:0] stride;
		logic signed [ACC_BITS-1:0] acc;
		stride = brg - prev_brg;
		acc = unwrapped + ACC_BITS'(fold_turn(stride));
		unwrapped = acc;
		if (min_ang > acc) begin
			min_ang = acc; min_x = vx; min_y = vy;
		end
		if (max_ang < acc) begin
			max_ang = acc; max_x = vx; max_y = vy;
		end
		prev_brg = brg;
	endtask

	task automatic track_vertex(input logic [COORD_BITS-1:0] vx,
			input logic [COORD_BITS-1:0] vy, input logic fin);
		longint dx, dy;
		logic [ANGLE_BITS-1:0] brg;
		dx = longint'($signed(vx)) - longint'($signed(vp_x));
		dy = longint'($signed(vy)) - longint'($signed(vp_y));
		brg = cordic_bearing(dx, dy);
		n_vertices++;
		if (first_pending) begin
			first_x = vx; first_y = vy;
			first_brg = brg; prev_brg = brg;
			unwrapped = ACC_BITS'(fold_turn(brg));
			min_ang = unwrapped; max_ang = unwrapped;
			min_x = vx; min_y = vy; max_x = vx; max_y = vy;
			first_pending = 1'b0;
		end else begin
			accumulate(brg, vx, vy);
		end
		if (fin) begin
			accumulate(first_brg, first_x, first_y);
			stash_extreme('{x: min_x, y: min_y,
				ang: 17'(fold_turn(min_ang[ANGLE_BITS-1:0])), side: 1'b0, run_end: 1'b0});
			stash_extreme('{x: max_x, y: max_y,
				ang: 17'(fold_turn(max_ang[ANGLE_BITS-1:0])), side: 1'b1, run_end: 1'b1});
			first_pending = 1'b1;
			n_polygons++;
		end
	endtask

	task automatic write_viewpoint(input logic [REG_IDX_BITS-1:0] idx,
			input logic [COORD_BITS-1:0] data);
		if (idx == REG_VIEWPOINT_X)
			vp_x = data;
		else if (idx == REG_VIEWPOINT_Y)
			vp_y = data;
		n_writes++;
	endtask

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		err_count++;
		$display("[%0t] mismatch on edge %0d: %s got 0x%0h expected 0x%0h",
			$realtime, n_extremes, what, got, want);
	endtask

	task automatic check_extreme();
		extreme_t want;
		if (pending_extremes.size() == 0) begin
			flag_mismatch("unexpected item", m_tdata, 0);
			return;
		end
		want = pending_extremes.pop_front();
		if (m_tdata[15:0] != want.x)
			flag_mismatch("edge_x", m_tdata[15:0], want.x);
		if (m_tdata[31:16] != want.y)
			flag_mismatch("edge_y", m_tdata[31:16], want.y);
		if (m_tdata[48:32] != want.ang)
			flag_mismatch("edge_angle", m_tdata[48:32], want.ang);
		if (m_tuser != want.side)
			flag_mismatch("side", m_tuser, want.side);
		if (m_tlast != want.run_end)
			flag_mismatch("run_end", m_tlast, want.run_end);
		n_extremes++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 50);
	endfunction

	// driver: vertex stream and register writes, one item in flight per channel
	int send_gap = 0, settle = 0;
	bit s_hold, c_hold;
	plan_t step;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tlast <= 1'b0;
			s_tdata <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			send_gap = 0;
			settle = 0;
		end else begin
			s_hold = s_tvalid;
			c_hold = cfg_valid;
			if (s_tvalid && s_tready) begin
				track_vertex(s_tdata[15:0], s_tdata[31:16], s_tlast);
				s_hold = 1'b0;
				send_gap = quiet_s ? 0 : pick_gap();
				if ($urandom_range(0, 63) == 0)
					quiet_s = !quiet_s;
			end
			if (cfg_valid && cfg_ready) begin
				write_viewpoint(cfg_index, cfg_data);
				c_hold = 1'b0;
			end
			settle = (pending_extremes.size() == 0) ? settle + 1 : 0;
			if (!s_hold && !c_hold && plan_q.size() > 0) begin
				if (plan_q[0].kind == PL_VERTEX) begin
					if (send_gap > 0) begin
						send_gap--;
					end else begin
						step = plan_q.pop_front();
						s_tdata <= {step.vy, step.vx};
						s_tlast <= step.fin;
						s_hold = 1'b1;
					end
				end else if (settle >= SETTLE_CYCLES) begin
					step = plan_q.pop_front();
					if (step.kind == PL_CFG) begin
						cfg_index <= step.idx;
						cfg_data <= step.data;
						c_hold = 1'b1;
					end
					settle = 0;
				end
			end
			s_tvalid <= s_hold;
			cfg_valid <= c_hold;
		end
	end

	// monitor: check edges and throttle the output side
	int stall = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_extreme();
				if ($urandom_range(0, 31) == 0)
					quiet_m = !quiet_m;
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (quiet_m || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
			end else begin
				stall = pick_gap();
				m_tready <= (stall == 0);
			end
		end
	end

	task automatic add_vertex(input logic [15:0] vx, input logic [15:0] vy, input logic fin);
		enqueue_plan('{kind: PL_VERTEX, idx: '0, data: '0, vx: vx, vy: vy, fin: fin});
		planned_vertices++;
	endtask

	task automatic add_cfg(input logic [REG_IDX_BITS-1:0] idx, input logic [15:0] data);
		enqueue_plan('{kind: PL_CFG, idx: idx, data: data, vx: '0, vy: '0, fin: 1'b0});
	endtask

	function automatic logic [15:0] pick_coord(input int mode, input logic [15:0] centre);
		case (mode)
			0: return 16'($urandom_range(0, 65535));
			1: return centre + 16'($urandom_range(0, 64) - 32);
			2: return centre + 16'($urandom_range(0, 8191) - 4096);
			default: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					3: return 16'hFFFF;
					default: return centre;
				endcase
			end
		endcase
	endfunction

	task automatic add_polygon(input int n, input int mode,
			input logic [15:0] cx, input logic [15:0] cy);
		for (int k = 0; k < n; k++)
			add_vertex(pick_coord(mode, cx), pick_coord(mode, cy), k == n - 1);
	endtask

	initial begin
		logic [15:0] cx, cy, rad;
		int n, r, phase, q;
		int dir_x[4], dir_y[4];
		dir_x = '{1, 0, -1, 0};
		dir_y = '{0, 1, 0, -1};

		// vertex at the viewpoint, bearing along the axis, half turn
		add_vertex(16'h0000, 16'h0000, 1'b1);
		add_vertex(16'h7FFF, 16'h0000, 1'b1);
		add_vertex(16'hFF00, 16'h0000, 1'b1);
		add_vertex(16'h0100, 16'h0100, 1'b0);
		add_vertex(16'hFF00, 16'h0100, 1'b0);
		add_vertex(16'hFF00, 16'hFF00, 1'b0);
		add_vertex(16'h0100, 16'hFF00, 1'b1);
		add_vertex(16'h8000, 16'h8000, 1'b0);
		add_vertex(16'h7FFF, 16'h7FFF, 1'b0);
		add_vertex(16'h8000, 16'h7FFF, 1'b0);
		add_vertex(16'h7FFF, 16'h8000, 1'b1);
		// ties keep the earliest vertex
		add_vertex(16'h0064, 16'h0000, 1'b0);
		add_vertex(16'h0064, 16'h0000, 1'b0);
		add_vertex(16'h0064, 16'h0000, 1'b1);
		// steps of exactly half a turn
		add_vertex(16'h0100, 16'h0000, 1'b0);
		add_vertex(16'hFF00, 16'h0000, 1'b0);
		add_vertex(16'h0100, 16'h0000, 1'b1);
		add_cfg(REG_VIEWPOINT_X, 16'h8000);
		add_cfg(REG_VIEWPOINT_Y, 16'h7FFF);
		add_vertex(16'h7FFF, 16'h8000, 1'b1);
		add_vertex(16'h8000, 16'h7FFF, 1'b0);
		add_vertex(16'h8000, 16'h8000, 1'b0);
		add_vertex(16'h7FFF, 16'h7FFF, 1'b1);
		add_cfg(REG_VIEWPOINT_X, 16'h7FFF);
		add_cfg(REG_VIEWPOINT_Y, 16'h8000);
		add_vertex(16'h8000, 16'h7FFF, 1'b0);
		add_vertex(16'h8000, 16'h8000, 1'b1);
		enqueue_plan('{kind: PL_DRAIN, idx: '0, data: '0, vx: '0, vy: '0, fin: 1'b0});

		phase = 0;
		planned_vertices = 0;
		while (planned_vertices < VERTEX_BUDGET) begin
			r = $urandom_range(0, 3);
			if (phase == 1 || r == 2) begin
				cx = 16'($urandom_range(0, 2047) - 1024);
				cy = 16'($urandom_range(0, 2047) - 1024);
			end else if (r == 0) begin
				cx = pick_coord(3, 16'h0000);
				cy = pick_coord(3, 16'h0000);
			end else begin
				cx = 16'($urandom_range(0, 65535));
				cy = 16'($urandom_range(0, 65535));
			end
			add_cfg(REG_VIEWPOINT_X, cx);
			add_cfg(REG_VIEWPOINT_Y, cy);
			if (phase == 1) begin
				// overlong polygon circling the viewpoint, drives the unwrapped angle past 24 bits
				rad = 16'($urandom_range(16, 1000));
				r = $urandom_range(0, 1);
				for (int k = 0; k < 540; k++) begin
					q = r ? (k % 4) : ((4 - (k % 4)) % 4);
					add_vertex(cx + 16'(dir_x[q] * int'(rad)) + 16'($urandom_range(0, 6) - 3),
						cy + 16'(dir_y[q] * int'(rad)) + 16'($urandom_range(0, 6) - 3),
						k == 539);
				end
			end else begin
				repeat ($urandom_range(3, 10)) begin
					r = $urandom_range(0, 99);
					n = (r < 15) ? 1 : (r < 30) ? 2 : $urandom_range(3, 10);
					add_polygon(n, $urandom_range(0, 3), cx, cy);
				end
			end
			if ($urandom_range(0, 2) == 0)
				enqueue_plan('{kind: PL_DRAIN, idx: '0, data: '0, vx: '0, vy: '0,
					fin: 1'b0});
			phase++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (plan_q.size() != 0 || s_tvalid || cfg_valid)
			@(posedge clk);
		while (pending_extremes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d vertices in %0d polygons, %0d edges checked, %0d viewpoint writes",
			n_vertices, n_polygons, n_extremes, n_writes);
		if (err_count == 0)
			$display("tb_polygon_angular_extent_top OK");
		else
			$display("tb_polygon_angular_extent_top NOT OK");
		$finish;
	end

	initial begin
		#1_500_000;
		$display("timeout with %0d edges outstanding", pending_extremes.size());
		$display("tb_polygon_angular_extent_top NOT OK");
		$finish;
	end

endmodule
